### src/che_pkg.sv
// ----------------------------------------------------------------------------
// che_pkg: shared types and constants for the canonical Huffman encoder
// Alphabet and code sizes, command and status codes, sequencer states and
// the control word of the shared step unit.
// ----------------------------------------------------------------------------
package che_pkg;

   localparam int SYMBOL_COUNT = 512;
   localparam int SYM_W        = $clog2(SYMBOL_COUNT);
   localparam int MAX_CODE_LEN = 32;
   localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
   localparam int HIST_DEPTH   = MAX_CODE_LEN + 1;
   localparam int HIST_AW      = $clog2(HIST_DEPTH);
   localparam int HIST_W       = $clog2(SYMBOL_COUNT + 1);
   localparam int CODE_W       = 32;

   typedef enum logic [1:0] {
      CMD_SET    = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_ENCODE = 2'd2,
      CMD_NOP    = 2'd3
   } che_cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_CODE   = 2'd1,
      ST_TOO_LONG  = 2'd2,
      ST_NOT_BUILT = 2'd3
   } che_status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SET_OLD,
      S_SET_DEC,
      S_SET_RDN,
      S_SET_INC,
      S_ENC,
      S_LEN_RD,
      S_LEN_ADD,
      S_SYM_RD,
      S_SYM_CHK,
      S_SYM_WR
   } che_state_type;

   typedef enum logic [1:0] {
      ALU_HIST_DEC,
      ALU_HIST_INC,
      ALU_CODE_STEP,
      ALU_NEXT_INC
   } che_alu_op_type;

   typedef struct packed {
      che_alu_op_type op;
      logic           first_len;
   } che_alu_ctl_type;

endpackage

### src/che_step_unit.sv
// ----------------------------------------------------------------------------
// che_step_unit: shared add/shift unit of the encoder sequencer
// One adder serves histogram updates, the first-code recurrence
// (code + count) << 1 and the per-length next-code increment.
// ----------------------------------------------------------------------------
module che_step_unit
   import che_pkg::*;
(
   input  che_alu_ctl_type    ctl,
   input  logic [CODE_W-1:0]  code_acc,
   input  logic [HIST_W-1:0]  hist_data,
   input  logic [CODE_W-1:0]  next_data,
   output logic [CODE_W-1:0]  result
);

   logic [CODE_W-1:0] opa;
   logic [CODE_W-1:0] opb;
   logic [CODE_W-1:0] sum;
   logic [CODE_W-1:0] hist_ext;

   assign hist_ext = {{(CODE_W-HIST_W){1'b0}}, hist_data};

   always_comb begin
      opa = code_acc;
      opb = '0;
      case (ctl.op)
         ALU_HIST_DEC: begin
            opa = hist_ext;
            opb = '1;
         end
         ALU_HIST_INC: begin
            opa = hist_ext;
            opb = CODE_W'(1);
         end
         ALU_CODE_STEP: begin
            // no codes are shorter than length one
            opa = code_acc;
            opb = ctl.first_len ? '0 : hist_ext;
         end
         ALU_NEXT_INC: begin
            opa = next_data;
            opb = CODE_W'(1);
         end
         default: begin
            opa = code_acc;
            opb = '0;
         end
      endcase
   end

   assign sum    = opa + opb;
   assign result = (ctl.op == ALU_CODE_STEP) ? {sum[CODE_W-2:0], 1'b0} : sum;

endmodule

### src/canonical_huffman_encoder_unit.sv
// ----------------------------------------------------------------------------
// canonical_huffman_encoder_unit: canonical Huffman code table and encoder
// Holds a code length per symbol, builds canonical codes on request and
// returns a symbol's code and length on encode.
// ----------------------------------------------------------------------------
// Commands are taken while busy is low and each gives one result beat on
// rsp_strobe, which the receiver must take in that cycle. After reset a
// clearing pass zeroes the length table and histogram with busy high.
// Encode before a build, a nop and an over-long set answer on the cycle
// after the accept; an encode after a build answers after a registered table
// read; a set reads the length table, then does two read-modify-writes of the
// histogram. A build runs the 32 first-code steps, then reads each symbol's
// length and writes a code for each symbol that has one; every step goes
// through one shared adder and single-port table reads.
module canonical_huffman_encoder_unit
   import che_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [LEN_W-1:0]  req_length_in,
   output logic              rsp_strobe,
   output logic [CODE_W-1:0] rsp_code_bits,
   output logic [LEN_W-1:0]  rsp_code_length,
   output logic [1:0]        rsp_status
);

   che_state_type     state_ff, state_in;
   logic [SYM_W-1:0]  idx_ff, idx_in;
   logic [SYM_W-1:0]  sym_ff, sym_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cur_len_ff, cur_len_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              built_ff, built_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_bits_ff, rsp_code_bits_in;
   logic [LEN_W-1:0]  rsp_code_length_ff, rsp_code_length_in;
   che_status_type    rsp_status_ff, rsp_status_in;

   // length table
   logic [LEN_W-1:0]  length_mem_ff [SYMBOL_COUNT];
   logic              lt_we;
   logic [SYM_W-1:0]  lt_waddr, lt_raddr;
   logic [LEN_W-1:0]  lt_wdata, lt_rd_ff;

   // code table
   logic [CODE_W-1:0] code_mem_ff [SYMBOL_COUNT];
   logic              ct_we;
   logic [SYM_W-1:0]  ct_raddr;
   logic [CODE_W-1:0] ct_rd_ff;

   // length histogram
   logic [HIST_W-1:0]  hist_mem_ff [HIST_DEPTH];
   logic               hist_we;
   logic [HIST_AW-1:0] hist_waddr, hist_raddr;
   logic [HIST_W-1:0]  hist_wdata, hist_rd_ff;

   // next code per length
   logic [CODE_W-1:0]  next_mem_ff [HIST_DEPTH];
   logic               nxt_we;
   logic [HIST_AW-1:0] nxt_waddr, nxt_raddr;
   logic [CODE_W-1:0]  nxt_rd_ff;

   che_alu_ctl_type   alu_ctl;
   logic [CODE_W-1:0] alu_result;
   logic              accept;
   logic              last_sym;

   che_step_unit u_step (
      .ctl       (alu_ctl),
      .code_acc  (code_ff),
      .hist_data (hist_rd_ff),
      .next_data (nxt_rd_ff),
      .result    (alu_result)
   );

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign last_sym = (idx_ff == SYM_W'(SYMBOL_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff             <= sym_in;
      len_ff             <= len_in;
      cur_len_ff         <= cur_len_in;
      code_ff            <= code_in;
      rsp_code_bits_ff   <= rsp_code_bits_in;
      rsp_code_length_ff <= rsp_code_length_in;
      rsp_status_ff      <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (lt_we) begin
         length_mem_ff[lt_waddr] <= lt_wdata;
      end
      lt_rd_ff <= length_mem_ff[lt_raddr];
   end

   always_ff @(posedge clock) begin
      if (ct_we) begin
         code_mem_ff[idx_ff] <= nxt_rd_ff;
      end
      ct_rd_ff <= code_mem_ff[ct_raddr];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem_ff[hist_waddr] <= hist_wdata;
      end
      hist_rd_ff <= hist_mem_ff[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         next_mem_ff[nxt_waddr] <= alu_result;
      end
      nxt_rd_ff <= next_mem_ff[nxt_raddr];
   end

   always_comb begin
      state_in           = state_ff;
      idx_in             = idx_ff;
      sym_in             = sym_ff;
      len_in             = len_ff;
      cur_len_in         = cur_len_ff;
      code_in            = code_ff;
      built_in           = built_ff;
      rsp_valid_in       = 1'b0;
      rsp_code_bits_in   = '0;
      rsp_code_length_in = '0;
      rsp_status_in      = ST_OK;
      lt_we              = 1'b0;
      lt_waddr           = sym_ff;
      lt_wdata           = len_ff;
      lt_raddr           = req_symbol;
      ct_we              = 1'b0;
      ct_raddr           = req_symbol;
      hist_we            = 1'b0;
      hist_waddr         = HIST_AW'(cur_len_ff);
      hist_wdata         = alu_result[HIST_W-1:0];
      hist_raddr         = HIST_AW'(len_ff);
      nxt_we             = 1'b0;
      nxt_waddr          = idx_ff[HIST_AW-1:0];
      nxt_raddr          = HIST_AW'(lt_rd_ff);
      alu_ctl.op         = ALU_HIST_INC;
      alu_ctl.first_len  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            lt_we    = 1'b1;
            lt_waddr = idx_ff;
            lt_wdata = '0;
            if (idx_ff < SYM_W'(HIST_DEPTH)) begin
               hist_we    = 1'b1;
               hist_waddr = idx_ff[HIST_AW-1:0];
               hist_wdata = '0;
            end
            if (last_sym) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + SYM_W'(1);
            end
         end

         S_IDLE: begin
            if (accept) begin
               case (che_cmd_type'(req_command))
                  CMD_SET: begin
                     if (req_length_in > LEN_W'(MAX_CODE_LEN)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_TOO_LONG;
                     end else begin
                        sym_in   = req_symbol;
                        len_in   = req_length_in;
                        state_in = S_SET_OLD;
                     end
                  end
                  CMD_BUILD: begin
                     idx_in   = SYM_W'(1);
                     code_in  = '0;
                     state_in = S_LEN_RD;
                  end
                  CMD_ENCODE: begin
                     if (!built_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_BUILT;
                     end else begin
                        state_in = S_ENC;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_SET_OLD: begin
            cur_len_in = lt_rd_ff;
            lt_we      = 1'b1;
            hist_raddr = HIST_AW'(lt_rd_ff);
            built_in   = 1'b0;
            state_in   = S_SET_DEC;
         end

         S_SET_DEC: begin
            alu_ctl.op = ALU_HIST_DEC;
            if (cur_len_ff != '0) begin
               hist_we = 1'b1;
            end
            state_in = S_SET_RDN;
         end

         S_SET_RDN: begin
            hist_raddr = HIST_AW'(len_ff);
            state_in   = S_SET_INC;
         end

         S_SET_INC: begin
            alu_ctl.op = ALU_HIST_INC;
            hist_waddr = HIST_AW'(len_ff);
            if (len_ff != '0) begin
               hist_we = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end

         S_ENC: begin
            rsp_valid_in = 1'b1;
            if (lt_rd_ff == '0) begin
               rsp_status_in = ST_NO_CODE;
            end else begin
               rsp_code_bits_in   = ct_rd_ff;
               rsp_code_length_in = lt_rd_ff;
               rsp_status_in      = ST_OK;
            end
            state_in = S_IDLE;
         end

         S_LEN_RD: begin
            hist_raddr = idx_ff[HIST_AW-1:0] - HIST_AW'(1);
            state_in   = S_LEN_ADD;
         end

         S_LEN_ADD: begin
            // next = (next + count one length shorter) << 1
            alu_ctl.op        = ALU_CODE_STEP;
            alu_ctl.first_len = (idx_ff == SYM_W'(1));
            code_in           = alu_result;
            nxt_we            = 1'b1;
            nxt_waddr         = idx_ff[HIST_AW-1:0];
            if (idx_ff == SYM_W'(MAX_CODE_LEN)) begin
               idx_in   = '0;
               state_in = S_SYM_RD;
            end else begin
               idx_in   = idx_ff + SYM_W'(1);
               state_in = S_LEN_RD;
            end
         end

         S_SYM_RD: begin
            lt_raddr = idx_ff;
            state_in = S_SYM_CHK;
         end

         S_SYM_CHK, S_SYM_WR: begin
            if (state_ff == S_SYM_CHK) begin
               cur_len_in = lt_rd_ff;
               nxt_raddr  = HIST_AW'(lt_rd_ff);
            end else begin
               ct_we      = 1'b1;
               alu_ctl.op = ALU_NEXT_INC;
               nxt_we     = 1'b1;
               nxt_waddr  = HIST_AW'(cur_len_ff);
            end
            if (state_ff == S_SYM_CHK && lt_rd_ff != '0) begin
               state_in = S_SYM_WR;
            end else if (last_sym) begin
               // walk done: codes are valid from here on
               idx_in        = '0;
               built_in      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end else begin
               idx_in   = idx_ff + SYM_W'(1);
               state_in = S_SYM_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_code_bits   = rsp_code_bits_ff;
   assign rsp_code_length = rsp_code_length_ff;
   assign rsp_status      = rsp_status_ff;

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("accepted beat neither started work nor answered");

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_code_length <= LEN_W'(MAX_CODE_LEN)))
      else $error("code length above maximum");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_code_bits == '0 && rsp_code_length == '0))
      else $error("failed beat carries a code");

   a_built_end: assert property (@(posedge clock) disable iff (reset)
      $rose(built_ff) |-> rsp_strobe)
      else $error("table marked built without a build result beat");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_strobe)
      else $error("result beat during clearing pass");

endmodule
